FILE: rtl/fcpt_pkg.sv
// Package with the constants, codes and helper functions of the four-channel timer unit.
`timescale 1ns / 1ps
`default_nettype none
package fcpt_pkg;

  localparam int NUM_TIMERS  = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int PRE_WIDTH   = 14;
  localparam int IDX_WIDTH   = 2;
  localparam int IRQ_WIDTH   = 4;
  localparam int ADDR_WIDTH  = 13;

  typedef logic [COUNT_WIDTH-1:0] word_t;
  typedef logic [PRE_WIDTH-1:0]   pre_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    OFF_COUNT   = 8'h00,
    OFF_MODE    = 8'h10,
    OFF_COMPARE = 8'h20,
    OFF_HOLD    = 8'h30
  } reg_off_t;

  localparam int BIT_ZRET = 6;
  localparam int BIT_CUE  = 7;
  localparam int BIT_CMPE = 8;
  localparam int BIT_OVFE = 9;
  localparam int BIT_FCMP = 10;
  localparam int BIT_FOVF = 11;

  localparam word_t FLAG_MASK = word_t'(16'h0C00);
  localparam pre_t  DIV_MAX   = pre_t'(9370);

  function automatic pre_t divisor_of(input logic [1:0] sel);
    pre_t d;
    case (sel)
      2'd0:    d = pre_t'(1);
      2'd1:    d = pre_t'(16);
      2'd2:    d = pre_t'(256);
      default: d = DIV_MAX;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/four_channel_prescaled_timer_unit.sv
// Top level of the four-channel prescaled timer unit with its bus request and result ports.
//
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_cmd, in_bus_address, in_write_data
// out_     output     out_valid / out_ready  out_read_data, out_irq_pulse
//
// A request is captured in an input register; when the result register can take it, the timer
// registers are updated from it and the result register is loaded.
// One request is taken every cycle while the result is not stalled; the rate is set by the single timer update stage.
// The synchronous reset clears every timer register and empties both stages.
// A stalled result holds the update stage, and the input register takes a request only while it is empty.
`timescale 1ns / 1ps
`default_nettype none
module four_channel_prescaled_timer_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [1:0]                         in_cmd,
  input  wire  [fcpt_pkg::ADDR_WIDTH-1:0]    in_bus_address,
  input  wire  [fcpt_pkg::COUNT_WIDTH-1:0]   in_write_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [fcpt_pkg::COUNT_WIDTH-1:0]   out_read_data,
  output logic [fcpt_pkg::IRQ_WIDTH-1:0]     out_irq_pulse
);
  import fcpt_pkg::*;

  logic                  req_valid_r;
  cmd_t                  req_cmd_r;
  logic [ADDR_WIDTH-1:0] req_addr_r;
  word_t                 req_data_r;

  logic                  out_valid_r;
  word_t                 out_read_data_r;
  logic [IRQ_WIDTH-1:0]  out_irq_r;

  word_t count_r   [NUM_TIMERS];
  word_t compare_r [NUM_TIMERS];
  word_t mode_r    [NUM_TIMERS];
  word_t hold_r    [NUM_TIMERS];
  pre_t  pre_r     [NUM_TIMERS];

  word_t count_nxt   [NUM_TIMERS];
  word_t compare_nxt [NUM_TIMERS];
  word_t mode_nxt    [NUM_TIMERS];
  word_t hold_nxt    [NUM_TIMERS];
  pre_t  pre_nxt     [NUM_TIMERS];

  logic                  advance;
  logic [IDX_WIDTH-1:0]  sel_idx;
  logic [7:0]            sel_off;
  logic                  sel_ok;
  word_t                 rd_nxt;
  logic [IRQ_WIDTH-1:0]  irq_nxt;

  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  assign sel_idx = req_addr_r[ADDR_WIDTH-1 -: IDX_WIDTH];
  assign sel_off = req_addr_r[7:0];
  assign sel_ok  = int'(sel_idx) < NUM_TIMERS;

  always_comb begin
    logic [COUNT_WIDTH:0] inc;
    word_t                m;
    rd_nxt  = '0;
    irq_nxt = '0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      count_nxt[k]   = count_r[k];
      compare_nxt[k] = compare_r[k];
      mode_nxt[k]    = mode_r[k];
      hold_nxt[k]    = hold_r[k];
      pre_nxt[k]     = pre_r[k];
    end
    inc = '0;
    m   = '0;
    case (req_cmd_r)
      CMD_TICK: begin
        for (int k = 0; k < NUM_TIMERS; k++) begin
          if (mode_r[k][BIT_CUE]) begin
            if (pre_r[k] > pre_t'(1)) begin
              pre_nxt[k] = pre_r[k] - pre_t'(1);
            end else begin
              pre_nxt[k] = divisor_of(mode_r[k][1:0]);
              inc = {1'b0, count_r[k]} + (COUNT_WIDTH+1)'(1);
              if (inc[COUNT_WIDTH-1:0] == compare_r[k]) begin
                if (mode_r[k][BIT_CMPE]) begin
                  mode_nxt[k][BIT_FCMP] = 1'b1;
                  irq_nxt[k] = 1'b1;
                end
                if (mode_r[k][BIT_ZRET]) begin
                  inc = '0;
                end
              end
              if (inc[COUNT_WIDTH] && mode_r[k][BIT_OVFE]) begin
                mode_nxt[k][BIT_FOVF] = 1'b1;
                irq_nxt[k] = 1'b1;
              end
              count_nxt[k] = inc[COUNT_WIDTH-1:0];
            end
          end
        end
      end
      CMD_READ: begin
        if (sel_ok) begin
          case (sel_off)
            OFF_COUNT:   rd_nxt = count_r[sel_idx];
            OFF_MODE:    rd_nxt = mode_r[sel_idx];
            OFF_COMPARE: rd_nxt = compare_r[sel_idx];
            OFF_HOLD:    rd_nxt = hold_r[sel_idx];
            default:     rd_nxt = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (sel_ok) begin
          case (sel_off)
            OFF_COUNT: begin
              count_nxt[sel_idx] = req_data_r;
              pre_nxt[sel_idx]   = divisor_of(mode_r[sel_idx][1:0]);
            end
            OFF_MODE: begin
              m = (mode_r[sel_idx] & FLAG_MASK) | (req_data_r & ~FLAG_MASK);
              m = m & ~(req_data_r & FLAG_MASK);
              mode_nxt[sel_idx] = m;
              pre_nxt[sel_idx]  = divisor_of(m[1:0]);
            end
            OFF_COMPARE: compare_nxt[sel_idx] = req_data_r;
            OFF_HOLD:    hold_nxt[sel_idx]    = req_data_r;
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd_r  <= cmd_t'(in_cmd);
      req_addr_r <= in_bus_address;
      req_data_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data_r <= rd_nxt;
      out_irq_r       <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        count_r[k]   <= '0;
        compare_r[k] <= '0;
        mode_r[k]    <= '0;
        hold_r[k]    <= '0;
        pre_r[k]     <= '0;
      end
    end else if (advance) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        count_r[k]   <= count_nxt[k];
        compare_r[k] <= compare_nxt[k];
        mode_r[k]    <= mode_nxt[k];
        hold_r[k]    <= hold_nxt[k];
        pre_r[k]     <= pre_nxt[k];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq_pulse = out_irq_r;

  // A request other than a tick never raises an interrupt.
  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance && req_cmd_r != CMD_TICK |=> out_irq_pulse == '0)
    else $error("interrupt raised by a non-tick request");

  // A tick returns no read data.
  a_no_data_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance && req_cmd_r == CMD_TICK |=> out_read_data == '0)
    else $error("read data returned on a tick");

  // An empty result register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty result register");

  // The update stage only advances while a request is held in the input register.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(count_r[0]) && $stable(mode_r[0]) && $stable(pre_r[0]))
    else $error("timer state changed without a request");

  genvar g;
  for (g = 0; g < NUM_TIMERS; g++) begin : g_pre_chk
    a_pre_range: assert property (@(posedge clk) disable iff (!rst_n)
      pre_r[g] <= DIV_MAX)
      else $error("prescaler count above largest divisor");
  end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the four-channel prescaled timer unit, with its scoreboard class.
`timescale 1ns / 1ps
import fcpt_pkg::*;

typedef struct packed {
  word_t                rd;
  logic [IRQ_WIDTH-1:0] irq;
} timer_result_t;

class timer_scoreboard;
  word_t         cnt_r  [NUM_TIMERS];
  word_t         cmp_r  [NUM_TIMERS];
  word_t         mode_r [NUM_TIMERS];
  word_t         hold_r [NUM_TIMERS];
  pre_t          pre_r  [NUM_TIMERS];
  timer_result_t awaited[$];
  int            n_err;
  int            n_checked;
  int            n_ticks;
  int            n_reads;
  int            n_writes;
  int            n_irq;

  function new();
    for (int k = 0; k < NUM_TIMERS; k++) begin
      cnt_r[k]  = '0;
      cmp_r[k]  = '0;
      mode_r[k] = '0;
      hold_r[k] = '0;
      pre_r[k]  = '0;
    end
    n_err     = 0;
    n_checked = 0;
    n_ticks   = 0;
    n_reads   = 0;
    n_writes  = 0;
    n_irq     = 0;
  endfunction

  function pre_t prescale_div(logic [1:0] sel);
    case (sel)
      2'd0:    return pre_t'(1);
      2'd1:    return pre_t'(16);
      2'd2:    return pre_t'(256);
      default: return pre_t'(9370);
    endcase
  endfunction

  // A compare match is handled before the wrap, and a return to zero hides the wrap.
  function bit advance_counter(int k);
    logic [COUNT_WIDTH:0] nxt;
    word_t                m;
    bit                   fire;
    nxt  = {1'b0, cnt_r[k]} + 1'b1;
    m    = mode_r[k];
    fire = 1'b0;
    if (nxt[COUNT_WIDTH-1:0] == cmp_r[k]) begin
      if (m[BIT_CMPE]) begin
        mode_r[k][BIT_FCMP] = 1'b1;
        fire = 1'b1;
      end
      if (m[BIT_ZRET]) begin
        nxt = '0;
      end
    end
    if (nxt[COUNT_WIDTH] && m[BIT_OVFE]) begin
      mode_r[k][BIT_FOVF] = 1'b1;
      fire = 1'b1;
    end
    cnt_r[k] = nxt[COUNT_WIDTH-1:0];
    return fire;
  endfunction

  function logic [IRQ_WIDTH-1:0] tick_timers();
    logic [IRQ_WIDTH-1:0] irq;
    irq = '0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      if (!mode_r[k][BIT_CUE]) continue;
      if (pre_r[k] > pre_t'(1)) begin
        pre_r[k] = pre_r[k] - 1'b1;
      end else begin
        pre_r[k] = prescale_div(mode_r[k][1:0]);
        if (advance_counter(k)) irq[k] = 1'b1;
      end
    end
    return irq;
  endfunction

  function word_t read_reg(int k, logic [7:0] off);
    case (off)
      OFF_COUNT:   return cnt_r[k];
      OFF_MODE:    return mode_r[k];
      OFF_COMPARE: return cmp_r[k];
      OFF_HOLD:    return hold_r[k];
      default:     return '0;
    endcase
  endfunction

  // Flag bits written as one are cleared and written as zero are kept.
  function void write_reg(int k, logic [7:0] off, word_t d);
    word_t m;
    case (off)
      OFF_COUNT: begin
        cnt_r[k] = d;
        pre_r[k] = prescale_div(mode_r[k][1:0]);
      end
      OFF_MODE: begin
        m = (mode_r[k] & FLAG_MASK) | (d & ~FLAG_MASK);
        m = m & ~(d & FLAG_MASK);
        mode_r[k] = m;
        pre_r[k] = prescale_div(m[1:0]);
      end
      OFF_COMPARE: cmp_r[k] = d;
      OFF_HOLD:    hold_r[k] = d;
      default: ;
    endcase
  endfunction

  function void note_request(logic [1:0] c, logic [ADDR_WIDTH-1:0] a, word_t d);
    timer_result_t e;
    int            k;
    e.rd  = '0;
    e.irq = '0;
    k     = int'(a[12:11]);
    case (c)
      CMD_TICK: begin
        e.irq = tick_timers();
        n_ticks++;
      end
      CMD_READ: begin
        if (k < NUM_TIMERS) e.rd = read_reg(k, a[7:0]);
        n_reads++;
      end
      CMD_WRITE: begin
        if (k < NUM_TIMERS) write_reg(k, a[7:0], d);
        n_writes++;
      end
      default: ;
    endcase
    awaited.push_back(e);
  endfunction

  function void check_result(word_t rd, logic [IRQ_WIDTH-1:0] irq);
    timer_result_t e;
    if (awaited.size() == 0) begin
      $error("Unexpected result: read_data %h, irq_pulse %h", rd, irq);
      n_err++;
      return;
    end
    e = awaited.pop_front();
    n_checked++;
    if (e.irq != '0) n_irq++;
    if (rd !== e.rd) begin
      $error("read_data mismatch: expected %h, actual %h", e.rd, rd);
      n_err++;
    end
    if (irq !== e.irq) begin
      $error("irq_pulse mismatch: expected %h, actual %h", e.irq, irq);
      n_err++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb_top;
  localparam int    CYCLE_LIMIT = 1_000_000;
  localparam int    ITEM_TARGET = 850;
  localparam word_t M_ZRET = word_t'(1) << BIT_ZRET;
  localparam word_t M_CUE  = word_t'(1) << BIT_CUE;
  localparam word_t M_CMPE = word_t'(1) << BIT_CMPE;
  localparam word_t M_OVFE = word_t'(1) << BIT_OVFE;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_cmd         = '0;
  logic [ADDR_WIDTH-1:0] in_bus_address = '0;
  word_t                 in_write_data  = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  word_t                 out_read_data;
  logic [IRQ_WIDTH-1:0]  out_irq_pulse;

  bit              calm       = 1'b0;
  int              stall_left = 0;
  int              cycles     = 0;
  int              n_sent     = 0;
  timer_scoreboard sb;

  four_channel_prescaled_timer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_irq_pulse  (out_irq_pulse)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_off();
    case ($urandom_range(0, 6))
      0:       return OFF_COUNT;
      1:       return OFF_MODE;
      2:       return OFF_COMPARE;
      3:       return OFF_HOLD;
      4:       return 8'($urandom_range(0, 255));
      default: return OFF_MODE;
    endcase
  endfunction

  function automatic logic [ADDR_WIDTH-1:0] reg_addr(int k, logic [7:0] off, logic [2:0] junk);
    return {2'(k), junk, off};
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && !calm && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_read_data, out_irq_pulse);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input cmd_t c, input logic [ADDR_WIDTH-1:0] a, input word_t d);
    int gap;
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_bus_address <= a;
    in_write_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_request(c, a, d);
    n_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic bus_write(input int k, input logic [7:0] off, input word_t d,
                           input logic [2:0] junk);
    send_request(CMD_WRITE, reg_addr(k, off, junk), d);
  endtask

  task automatic bus_read(input int k, input logic [7:0] off, input logic [2:0] junk);
    send_request(CMD_READ, reg_addr(k, off, junk), word_t'($urandom));
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_request(CMD_TICK, ADDR_WIDTH'($urandom), word_t'($urandom));
  endtask

  // Sets one timer up, mostly close to a compare match or a wrap, and lets it run.
  task automatic timer_scenario();
    int    k;
    int    r;
    int    n;
    word_t cmp_v;
    word_t cnt_v;
    word_t m;
    k = $urandom_range(0, NUM_TIMERS - 1);
    r = $urandom_range(0, 99);
    m = word_t'($urandom);
    m[1:0] = (r < 60) ? 2'd0 : (r < 88) ? 2'd1 : (r < 98) ? 2'd2 : 2'd3;
    m[BIT_CUE] = ($urandom_range(0, 9) != 0);
    cmp_v = word_t'($urandom);
    case ($urandom_range(0, 3))
      0: cnt_v = cmp_v - word_t'($urandom_range(1, 6));
      1: cnt_v = 16'hFFFF - word_t'($urandom_range(0, 6));
      2: begin
        cmp_v = '0;
        cnt_v = 16'hFFFF - word_t'($urandom_range(0, 3));
      end
      default: cnt_v = word_t'($urandom);
    endcase
    bus_write(k, OFF_COMPARE, cmp_v, 3'($urandom));
    bus_write(k, OFF_COUNT, cnt_v, 3'($urandom));
    bus_write(k, OFF_MODE, m, 3'($urandom));
    case (m[1:0])
      2'd0:    n = $urandom_range(1, 12);
      2'd1:    n = $urandom_range(8, 60);
      2'd2:    n = ($urandom_range(0, 3) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 20);
      default: n = $urandom_range(1, 20);
    endcase
    repeat (n) begin
      run_ticks(1);
      if ($urandom_range(0, 7) == 0) bus_read(k, pick_off(), 3'($urandom));
    end
    bus_read(k, OFF_MODE, 3'($urandom));
    bus_read(k, OFF_COUNT, 3'($urandom));
  endtask

  task automatic random_access();
    logic [ADDR_WIDTH-1:0] a;
    a = ADDR_WIDTH'($urandom_range(0, 8191));
    if ($urandom_range(0, 9) < 7) a[7:0] = pick_off();
    send_request($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, a, word_t'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, plain storage, ignored address bits, unknown offsets and the idle command.
    bus_read(0, OFF_COUNT, 3'b000);
    bus_read(0, OFF_MODE, 3'b000);
    bus_write(3, OFF_HOLD, 16'hFFFF, 3'b000);
    bus_read(3, OFF_HOLD, 3'b111);
    bus_write(3, OFF_HOLD, 16'h0000, 3'b101);
    bus_write(1, 8'hFF, 16'h1234, 3'b000);
    bus_read(1, 8'h40, 3'b000);
    send_request(CMD_NONE, 13'h1FFF, 16'hFFFF);

    // Compare match with return to zero.
    bus_write(1, OFF_COMPARE, 16'd2, 3'b000);
    bus_write(1, OFF_COUNT, 16'd0, 3'b000);
    bus_write(1, OFF_MODE, M_CUE | M_CMPE | M_ZRET, 3'b000);
    run_ticks(2);

    // Match and wrap together, first with return to zero and then without.
    bus_write(2, OFF_COUNT, 16'hFFFF, 3'b000);
    bus_write(2, OFF_MODE, M_CUE | M_CMPE | M_OVFE | M_ZRET, 3'b000);
    run_ticks(1);
    bus_read(2, OFF_MODE, 3'b000);
    bus_write(2, OFF_COUNT, 16'hFFFF, 3'b000);
    bus_write(2, OFF_MODE, M_CUE | M_CMPE | M_OVFE | FLAG_MASK, 3'b000);
    run_ticks(1);
    bus_read(2, OFF_MODE, 3'b000);

    // Overflow alone, then a mode of all ones, which also clears both flags.
    bus_write(3, OFF_COUNT, 16'hFFFF, 3'b000);
    bus_write(3, OFF_MODE, M_CUE | M_OVFE, 3'b000);
    run_ticks(1);
    bus_write(0, OFF_MODE, 16'hFFFF, 3'b000);
    bus_read(0, OFF_MODE, 3'b000);

    while (n_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) calm <= ~calm;
      case ($urandom_range(0, 99)) inside
        [0:59]:  timer_scenario();
        [60:84]: random_access();
        [85:94]: run_ticks($urandom_range(1, 20));
        default: send_request(CMD_NONE, ADDR_WIDTH'($urandom), word_t'($urandom));
      endcase
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests: %0d ticks, %0d reads, %0d writes.",
             n_sent, sb.n_ticks, sb.n_reads, sb.n_writes);
    $display("Checked %0d results, %0d of them with an interrupt pulse, %0d errors.",
             sb.n_checked, sb.n_irq, sb.n_err);
    if (sb.n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/fcpt_pkg.sv
rtl/four_channel_prescaled_timer_unit.sv
sim/tb_top.sv
